>>> hdl/psg_pkg.sv
`default_nettype none
package psg_pkg;

    localparam int LinesInFieldDef   = 310;
    localparam int VsyncHalfLinesDef = 5;

    localparam int AddrW = 5;
    localparam int DataW = 32;

    typedef enum logic [2:0] {
        PH_LONG  = 3'd0,
        PH_SHORT = 3'd1,
        PH_TOP   = 3'd2,
        PH_VIS   = 3'd3,
        PH_BOT   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        REG_LINE_TICKS  = 3'd0,
        REG_HSYNC_TICKS = 3'd1,
        REG_LONG_TICKS  = 3'd2,
        REG_SHORT_TICKS = 3'd3,
        REG_BPORCH      = 3'd4,
        REG_ACTIVE      = 3'd5,
        REG_FIRST_VIS   = 3'd6,
        REG_VIS_COUNT   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] line_ticks;
        logic [15:0] hsync_ticks;
        logic [15:0] long_sync_ticks;
        logic [15:0] short_sync_ticks;
        logic [15:0] back_porch_ticks;
        logic [15:0] active_ticks;
        logic [8:0]  first_visible_line;
        logic [8:0]  visible_line_count;
    } t_cfg;

    typedef struct packed {
        logic       sync_level;
        logic       video_gate;
        logic       field_start;
        logic       vblank_start;
        logic [2:0] field_phase;
        logic [8:0] visible_line;
    } t_result;

    localparam t_cfg CfgReset = '{
        line_ticks:         16'd1280,
        hsync_ticks:        16'd94,
        long_sync_ticks:    16'd546,
        short_sync_ticks:   16'd47,
        back_porch_ticks:   16'd223,
        active_ticks:       16'd819,
        first_visible_line: 9'd39,
        visible_line_count: 9'd256
    };

endpackage
`default_nettype wire

>>> hdl/psg_regs.sv
`default_nettype none
module psg_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [psg_pkg::AddrW-1:0] paddr,
    input  wire logic [psg_pkg::DataW-1:0] pwdata,
    output logic      [psg_pkg::DataW-1:0] prdata,
    output logic                           pready,
    output psg_pkg::t_cfg                  o_cfg
);
    import psg_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[AddrW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CfgReset;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_LINE_TICKS:  r_cfg.line_ticks         <= pwdata[15:0];
                REG_HSYNC_TICKS: r_cfg.hsync_ticks        <= pwdata[15:0];
                REG_LONG_TICKS:  r_cfg.long_sync_ticks    <= pwdata[15:0];
                REG_SHORT_TICKS: r_cfg.short_sync_ticks   <= pwdata[15:0];
                REG_BPORCH:      r_cfg.back_porch_ticks   <= pwdata[15:0];
                REG_ACTIVE:      r_cfg.active_ticks       <= pwdata[15:0];
                REG_FIRST_VIS:   r_cfg.first_visible_line <= pwdata[8:0];
                REG_VIS_COUNT:   r_cfg.visible_line_count <= pwdata[8:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_LINE_TICKS:  prdata = DataW'(r_cfg.line_ticks);
            REG_HSYNC_TICKS: prdata = DataW'(r_cfg.hsync_ticks);
            REG_LONG_TICKS:  prdata = DataW'(r_cfg.long_sync_ticks);
            REG_SHORT_TICKS: prdata = DataW'(r_cfg.short_sync_ticks);
            REG_BPORCH:      prdata = DataW'(r_cfg.back_porch_ticks);
            REG_ACTIVE:      prdata = DataW'(r_cfg.active_ticks);
            REG_FIRST_VIS:   prdata = DataW'(r_cfg.first_visible_line);
            REG_VIS_COUNT:   prdata = DataW'(r_cfg.visible_line_count);
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/psg_timing.sv
`default_nettype none
module psg_timing #(
    parameter int LINES_IN_FIELD   = psg_pkg::LinesInFieldDef,
    parameter int VSYNC_HALF_LINES = psg_pkg::VsyncHalfLinesDef
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic            i_advance,
    input  wire psg_pkg::t_cfg   i_cfg,
    output psg_pkg::t_result     o_result
);
    import psg_pkg::*;

    localparam logic [9:0] LinesField = 10'(LINES_IN_FIELD);
    localparam logic [8:0] VsyncLines = 9'(VSYNC_HALF_LINES);

    t_phase      r_phase, n_phase;
    logic [8:0]  r_line, n_line;
    logic [15:0] r_tick, n_tick;

    // phase/counters after empty phases are skipped
    t_phase      w_ph;
    logic [8:0]  w_line;
    logic [15:0] w_tick;

    logic        w_e_top, w_e_vis, w_e_bot;
    logic [9:0]  w_fv_vc;
    logic [8:0]  w_lines;
    logic [15:0] w_half, w_period;
    logic [16:0] w_gate_lo;
    logic [17:0] w_gate_hi;
    logic [16:0] w_tick_inc;
    logic [9:0]  w_line_inc;

    assign w_fv_vc = 10'(i_cfg.first_visible_line) + 10'(i_cfg.visible_line_count);
    assign w_e_top = i_cfg.first_visible_line <= VsyncLines;
    assign w_e_vis = i_cfg.visible_line_count == 9'd0;
    assign w_e_bot = w_fv_vc >= LinesField;

    // skip chain: top -> visible -> bottom -> long sync (never empty)
    always_comb begin
        w_ph   = r_phase;
        w_line = r_line;
        w_tick = r_tick;
        if (w_ph == PH_TOP && w_e_top) begin
            w_ph   = PH_VIS;
            w_line = '0;
            w_tick = '0;
        end
        if (w_ph == PH_VIS && w_e_vis) begin
            w_ph   = PH_BOT;
            w_line = '0;
            w_tick = '0;
        end
        if (w_ph == PH_BOT && w_e_bot) begin
            w_ph   = PH_LONG;
            w_line = '0;
            w_tick = '0;
        end
    end

    always_comb begin
        unique case (w_ph)
            PH_LONG, PH_SHORT: w_lines = VsyncLines;
            PH_TOP:            w_lines = i_cfg.first_visible_line - VsyncLines;
            PH_VIS:            w_lines = i_cfg.visible_line_count;
            PH_BOT:            w_lines = 9'(LinesField - w_fv_vc);
            default:           w_lines = '0;
        endcase
    end

    assign w_half    = (w_ph == PH_LONG || w_ph == PH_SHORT) ?
                       {1'b0, i_cfg.line_ticks[15:1]} : i_cfg.line_ticks;
    assign w_period  = (w_half == 16'd0) ? 16'd1 : w_half;
    assign w_gate_lo = 17'(i_cfg.hsync_ticks) + 17'(i_cfg.back_porch_ticks);
    assign w_gate_hi = 18'(w_gate_lo) + 18'(i_cfg.active_ticks);

    // result fields
    always_comb begin
        o_result              = '0;
        o_result.sync_level   = 1'b1;
        o_result.field_phase  = w_ph;
        unique case (w_ph)
            PH_LONG:  o_result.sync_level = !(w_tick < i_cfg.long_sync_ticks);
            PH_SHORT: o_result.sync_level = !(w_tick < i_cfg.short_sync_ticks);
            PH_VIS: begin
                o_result.sync_level   = !(w_tick < i_cfg.hsync_ticks);
                o_result.video_gate   = (17'(w_tick) >= w_gate_lo) &&
                                        (18'(w_tick) < w_gate_hi);
                o_result.visible_line = w_line;
            end
            default:  o_result.sync_level = !(w_tick < i_cfg.hsync_ticks);
        endcase
        if (i_advance && w_line == 9'd0 && w_tick == 16'd0) begin
            if (w_ph == PH_LONG) begin
                o_result.field_start  = 1'b1;
                o_result.vblank_start = w_e_bot;
            end else if (w_ph == PH_BOT) begin
                o_result.vblank_start = 1'b1;
            end
        end
    end

    assign w_tick_inc = 17'(w_tick) + 17'd1;
    assign w_line_inc = 10'(w_line) + 10'd1;

    // next state
    always_comb begin
        n_phase = w_ph;
        n_line  = w_line;
        n_tick  = w_tick;
        if (i_advance) begin
            if (w_tick_inc >= 17'(w_period)) begin
                n_tick = '0;
                if (w_line_inc >= 10'(w_lines)) begin
                    n_line = '0;
                    unique case (w_ph)
                        PH_LONG:  n_phase = PH_SHORT;
                        PH_SHORT: n_phase = PH_TOP;
                        PH_TOP:   n_phase = PH_VIS;
                        PH_VIS:   n_phase = PH_BOT;
                        default:  n_phase = PH_LONG;
                    endcase
                end else begin
                    n_line = w_line_inc[8:0];
                end
            end else begin
                n_tick = w_tick_inc[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LONG;
            r_line  <= '0;
            r_tick  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_line  <= n_line;
            r_tick  <= n_tick;
        end
    end

endmodule
`default_nettype wire

>>> hdl/pal_progressive_sync_generator_unit.sv
// A word is held in the input register, then in the output register, from which it is offered.
// Throughput: one word per cycle unless the output stalls; input and output registers form a
// two-stage pipeline, and the timing counters update as a word leaves the input register.
// Reset (synchronous, active low): pipeline empty, timing at field start (long sync,
// line 0, tick 0), configuration registers back to their default values.
`default_nettype none
module pal_progressive_sync_generator_unit #(
    parameter int LINES_IN_FIELD   = psg_pkg::LinesInFieldDef,
    parameter int VSYNC_HALF_LINES = psg_pkg::VsyncHalfLinesDef
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [psg_pkg::AddrW-1:0] paddr,
    input  wire logic [psg_pkg::DataW-1:0] pwdata,
    output logic      [psg_pkg::DataW-1:0] prdata,
    output logic                           pready,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_advance,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic                           o_sync_level,
    output logic                           o_video_gate,
    output logic                           o_field_start,
    output logic                           o_vblank_start,
    output logic [2:0]                     o_field_phase,
    output logic [8:0]                     o_visible_line
);
    import psg_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;
    t_result r_out;
    logic    r_in_vld, r_in_adv, r_out_vld;
    logic    w_out_free, w_move;

    psg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    psg_timing #(
        .LINES_IN_FIELD   (LINES_IN_FIELD),
        .VSYNC_HALF_LINES (VSYNC_HALF_LINES)
    ) u_timing (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_move),
        .i_advance (r_in_adv),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_move     = r_in_vld && w_out_free;
    assign o_in_ready = !r_in_vld || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (w_out_free) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_adv <= i_advance;
        end
        if (w_move) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_sync_level   = r_out.sync_level;
    assign o_video_gate   = r_out.video_gate;
    assign o_field_start  = r_out.field_start;
    assign o_vblank_start = r_out.vblank_start;
    assign o_field_phase  = r_out.field_phase;
    assign o_visible_line = r_out.visible_line;

`ifndef ASSERT_OFF
    a_fs_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_field_start) |-> (o_field_phase == PH_LONG))
        else $error("field start outside long sync");

    a_gate_vis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_video_gate) |-> (o_field_phase == PH_VIS && o_sync_level))
        else $error("video gate outside visible region");

    a_vis_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_field_phase != PH_VIS) |-> (o_visible_line == 9'd0))
        else $error("visible line index set outside visible phase");

    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_move) |=> (r_in_vld && $stable(r_in_adv)))
        else $error("input register lost a word");
`endif

endmodule
`default_nettype wire

>>> tb/sv/pal_progressive_sync_generator_unit_test.sv
`timescale 1ns / 1ps
module pal_progressive_sync_generator_unit_test;
    import psg_pkg::*;

    localparam int LinesInField   = LinesInFieldDef;
    localparam int VsyncHalfLines = VsyncHalfLinesDef;
    localparam int CycleLimit     = 400000;
    localparam int SettleCycles   = 4;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [AddrW-1:0]   paddr;
    logic [DataW-1:0]   pwdata;
    logic [DataW-1:0]   prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_advance;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_sync_level;
    logic               o_video_gate;
    logic               o_field_start;
    logic               o_vblank_start;
    logic [2:0]         o_field_phase;
    logic [8:0]         o_visible_line;

    // timing model: settings and beam position
    t_cfg        timing_cfg;
    t_phase      beam_phase;
    logic [8:0]  beam_line;
    logic [15:0] beam_tick;

    t_result     sync_words_due[$];
    t_result     seen_word;
    t_result     due_word;
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned stall_left;
    bit          idling_on;

    pal_progressive_sync_generator_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_advance      (i_advance),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sync_level   (o_sync_level),
        .o_video_gate   (o_video_gate),
        .o_field_start  (o_field_start),
        .o_vblank_start (o_vblank_start),
        .o_field_phase  (o_field_phase),
        .o_visible_line (o_visible_line)
    );

    always #6 i_clk = ~i_clk;

    function automatic int unsigned lines_of(t_phase p);
        int unsigned fv;
        int unsigned vc;
        fv = timing_cfg.first_visible_line;
        vc = timing_cfg.visible_line_count;
        case (p)
            PH_LONG, PH_SHORT: return VsyncHalfLines;
            PH_TOP:  return (fv > VsyncHalfLines) ? fv - VsyncHalfLines : 0;
            PH_VIS:  return vc;
            PH_BOT:  return (LinesInField > fv + vc) ? LinesInField - fv - vc : 0;
            default: return 0;
        endcase
    endfunction

    // vsync phases count half lines; a zero period still takes one tick
    function automatic int unsigned ticks_of(t_phase p);
        int unsigned t;
        t = (p == PH_LONG || p == PH_SHORT) ? timing_cfg.line_ticks >> 1
                                            : timing_cfg.line_ticks;
        return (t == 0) ? 1 : t;
    endfunction

    function automatic t_phase next_phase(t_phase p);
        return (p == PH_BOT) ? PH_LONG : t_phase'(p + 3'd1);
    endfunction

    function automatic void skip_empty_phases();
        for (int i = 0; i < 5 && lines_of(beam_phase) == 0; i++) begin
            beam_phase = next_phase(beam_phase);
            beam_line  = '0;
            beam_tick  = '0;
        end
    endfunction

    function automatic t_result predict_word(bit adv);
        t_result     w;
        int unsigned t;
        int unsigned ln;
        int unsigned gate_lo;
        int unsigned gate_hi;
        skip_empty_phases();
        t  = beam_tick;
        ln = beam_line;
        w  = '0;
        w.field_phase = beam_phase;
        case (beam_phase)
            PH_LONG:  w.sync_level = (t >= timing_cfg.long_sync_ticks);
            PH_SHORT: w.sync_level = (t >= timing_cfg.short_sync_ticks);
            PH_VIS: begin
                w.sync_level   = (t >= timing_cfg.hsync_ticks);
                gate_lo        = 32'(timing_cfg.hsync_ticks) + 32'(timing_cfg.back_porch_ticks);
                gate_hi        = gate_lo + 32'(timing_cfg.active_ticks);
                w.video_gate   = (t >= gate_lo && t < gate_hi);
                w.visible_line = beam_line;
            end
            default:  w.sync_level = (t >= timing_cfg.hsync_ticks);
        endcase
        if (adv && ln == 0 && t == 0) begin
            if (beam_phase == PH_LONG) begin
                w.field_start  = 1'b1;
                w.vblank_start = (lines_of(PH_BOT) == 0);
            end else if (beam_phase == PH_BOT) begin
                w.vblank_start = 1'b1;
            end
        end
        if (adv) begin
            if (t + 1 >= ticks_of(beam_phase)) begin
                beam_tick = '0;
                if (ln + 1 >= lines_of(beam_phase)) begin
                    beam_line  = '0;
                    beam_phase = next_phase(beam_phase);
                end else begin
                    beam_line = beam_line + 9'd1;
                end
            end else begin
                beam_tick = beam_tick + 16'd1;
            end
            skip_empty_phases();
        end
        return w;
    endfunction

    function automatic logic [15:0] pick_width(int unsigned span);
        case ($urandom_range(0, 7))
            0:       return 16'($urandom);
            1:       return 16'hFFFF;
            2:       return 16'd0;
            default: return 16'($urandom_range(0, span + 1));
        endcase
    endfunction

    function automatic t_cfg random_timing();
        t_cfg       c;
        logic [8:0] fv;
        logic [8:0] vc;
        case ($urandom_range(0, 11))
            0:       c.line_ticks = 16'($urandom);
            1:       c.line_ticks = 16'hFFFF;
            2:       c.line_ticks = 16'd0;
            default: c.line_ticks = 16'($urandom_range(1, 3));
        endcase
        c.hsync_ticks      = pick_width(c.line_ticks);
        c.long_sync_ticks  = pick_width(c.line_ticks >> 1);
        c.short_sync_ticks = pick_width(c.line_ticks >> 1);
        c.back_porch_ticks = pick_width(c.line_ticks);
        c.active_ticks     = pick_width(c.line_ticks);
        case ($urandom_range(0, 5))
            0:       fv = 9'($urandom_range(0, 5));
            1:       fv = 9'd511;
            2:       fv = 9'($urandom);
            default: fv = 9'($urandom_range(6, 12));
        endcase
        case ($urandom_range(0, 6))
            0:       vc = 9'd0;
            1:       vc = 9'd511;
            2:       vc = (fv < 9'd310) ? 9'd310 - fv : 9'd0;  // no bottom blank
            3:       vc = 9'($urandom);
            default: vc = 9'($urandom_range(1, 40));
        endcase
        c.first_visible_line = fv;
        c.visible_line_count = vc;
        return c;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic send_word(input bit adv);
        i_in_valid <= 1'b1;
        i_advance  <= adv;
        do @(posedge i_clk); while (!o_in_ready);
        sync_words_due.push_back(predict_word(adv));
        if (idling_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (sync_words_due.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // write with junk above the register width, then read it back
    task automatic write_reg(input t_reg_idx idx, input logic [15:0] field);
        logic [DataW-1:0] mask;
        logic [DataW-1:0] stored;
        mask   = (idx == REG_FIRST_VIS || idx == REG_VIS_COUNT) ? 32'h1FF : 32'hFFFF;
        stored = {16'd0, field} & mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({idx, 2'b00});
        pwdata  <= stored | ($urandom & ~mask);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_LINE_TICKS:  timing_cfg.line_ticks         = stored[15:0];
            REG_HSYNC_TICKS: timing_cfg.hsync_ticks        = stored[15:0];
            REG_LONG_TICKS:  timing_cfg.long_sync_ticks    = stored[15:0];
            REG_SHORT_TICKS: timing_cfg.short_sync_ticks   = stored[15:0];
            REG_BPORCH:      timing_cfg.back_porch_ticks   = stored[15:0];
            REG_ACTIVE:      timing_cfg.active_ticks       = stored[15:0];
            REG_FIRST_VIS:   timing_cfg.first_visible_line = stored[8:0];
            REG_VIS_COUNT:   timing_cfg.visible_line_count = stored[8:0];
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== stored) begin
            mismatches++;
            $display("%0t ns: register %s expected %0d actual %0d",
                     $time, idx.name(), stored, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_timing(input t_cfg c);
        drain_pipeline();
        write_reg(REG_LINE_TICKS,  c.line_ticks);
        write_reg(REG_HSYNC_TICKS, c.hsync_ticks);
        write_reg(REG_LONG_TICKS,  c.long_sync_ticks);
        write_reg(REG_SHORT_TICKS, c.short_sync_ticks);
        write_reg(REG_BPORCH,      c.back_porch_ticks);
        write_reg(REG_ACTIVE,      c.active_ticks);
        write_reg(REG_FIRST_VIS,   {7'd0, c.first_visible_line});
        write_reg(REG_VIS_COUNT,   {7'd0, c.visible_line_count});
    endtask

    task automatic reset_run();
        timing_cfg  = CfgReset;
        beam_phase  = PH_LONG;
        beam_line   = '0;
        beam_tick   = '0;
        mismatches  = 0;
        stall_left  = 0;
        idling_on   = 1'b1;
        i_rst_n     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        i_in_valid  <= 1'b0;
        i_advance   <= 1'b0;
        i_out_ready <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // held words carry no pulse; the first advance marks field start
    task automatic test_hold_and_field_start();
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b1);
    endtask

    // tick count left beyond a shortened half line, long pulse wider than it
    task automatic test_counter_past_limit();
        repeat (4) send_word(1'b1);
        drain_pipeline();
        write_reg(REG_LINE_TICKS, 16'd4);
        write_reg(REG_LONG_TICKS, 16'hFFFF);
        write_reg(REG_SHORT_TICKS, 16'd0);
        repeat (5) send_word(1'b1);
    endtask

    // zero line period, top blank and visible skipped, then bottom skipped too
    task automatic test_empty_phases();
        drain_pipeline();
        write_reg(REG_LINE_TICKS, 16'd0);
        write_reg(REG_FIRST_VIS, 16'd0);
        write_reg(REG_VIS_COUNT, 16'd0);
        repeat (10) send_word(1'b1);
        drain_pipeline();
        write_reg(REG_FIRST_VIS, 16'd511);
        write_reg(REG_VIS_COUNT, 16'd511);
        repeat (2) send_word(1'b1);
    endtask

    task automatic test_random_fields();
        t_cfg        c;
        int unsigned words;
        for (int r = 0; r < 10; r++) begin
            case (r)
                0: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         9'd511, 9'd511};
                1: c = '{16'd2, 16'd1, 16'd1, 16'd1, 16'd0, 16'd1, 9'd6, 9'd1};
                default: c = random_timing();
            endcase
            apply_timing(c);
            idling_on = (r != 9) && ($urandom_range(0, 3) != 0);
            words = (r == 0) ? 40 : 120;
            repeat (words) send_word($urandom_range(0, 9) != 0);
        end
    endtask

    always @(posedge i_clk) begin
        if (idling_on && stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 11);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_word = {o_sync_level, o_video_gate, o_field_start, o_vblank_start,
                         o_field_phase, o_visible_line};
            if (sync_words_due.size() == 0) begin
                mismatches++;
                $display("%0t ns: word expected none actual %h", $time, seen_word);
            end else begin
                due_word = sync_words_due.pop_front();
                check_field("sync_level",   due_word.sync_level,   seen_word.sync_level);
                check_field("video_gate",   due_word.video_gate,   seen_word.video_gate);
                check_field("field_start",  due_word.field_start,  seen_word.field_start);
                check_field("vblank_start", due_word.vblank_start, seen_word.vblank_start);
                check_field("field_phase",  due_word.field_phase,  seen_word.field_phase);
                check_field("visible_line", due_word.visible_line, seen_word.visible_line);
            end
        end
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("pal_progressive_sync_generator_unit: mismatch");
            $finish;
        end
    end

    initial begin
        reset_run();
        test_hold_and_field_start();
        test_counter_past_limit();
        test_empty_phases();
        test_random_fields();
        drain_pipeline();
        if (mismatches == 0) begin
            $display("pal_progressive_sync_generator_unit: match");
        end else begin
            $display("pal_progressive_sync_generator_unit: mismatch");
        end
        $finish;
    end

endmodule
